/* rtl/crd_pkg.sv */
// Package for the conserved run detector: shared field widths, register
// indexes, the per-row comparison result type and the case folding helper.
// No dependencies.
package crd_pkg;

    localparam int MAX_ROWS       = 7;
    localparam int OTHER_ROWS_DEF = 7;
    localparam int POS_BITS       = 40;
    localparam int CONTIG_BITS    = 16;
    localparam int DEPTH_BITS     = 3;
    localparam int SAMPLE_BITS    = 3;
    localparam int SAMPLES        = 1 << SAMPLE_BITS;
    localparam int LEN_BITS       = 32;
    localparam int CFG_IDX_BITS   = 1;
    localparam int IN_DATA_BITS   = 160;
    localparam int OUT_DATA_BITS  = 104;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DEPTH  = 1'd1;

    localparam logic [7:0] GAP_CHAR = 8'h2D;

    // Result of comparing one row against the reference base.
    typedef struct packed {
        logic               hit;
        logic               hit_excl;
        logic [SAMPLES-1:0] sample_oh;
    } lane_res_t;

    // Column-wide fields carried alongside the lane results.
    typedef struct packed {
        logic                   flush;
        logic                   gap;
        logic [CONTIG_BITS-1:0] contig;
        logic [POS_BITS-1:0]    pos;
        logic [SAMPLES-1:0]     ref_oh;
    } col_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

/* rtl/crd_lane.sv */
// One comparison lane of the conserved run detector: checks one row base
// against the upper-cased reference base. Depends on crd_pkg.
module crd_lane (
    input  logic [7:0]                       row_base,
    input  logic [7:0]                       ref_up,
    input  logic                             present,
    input  logic                             excluded,
    input  logic [crd_pkg::SAMPLE_BITS-1:0]  sample,
    output crd_pkg::lane_res_t               res
);
    import crd_pkg::*;

    logic hit;

    assign hit = present && (upcase(row_base) == ref_up);

    always_comb
    begin
        res.hit       = hit;
        res.hit_excl  = hit && excluded;
        res.sample_oh = hit ? (SAMPLES'(1) << sample) : '0;
    end

endmodule

/* rtl/crd_merge.sv */
// Merge stage of the conserved run detector: combines lane results into the
// column depth, tracks the open run and holds the result register. Depends on crd_pkg.
module crd_merge #(
    parameter int OTHER_ROWS = crd_pkg::OTHER_ROWS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [crd_pkg::LEN_BITS-1:0]          cfg_data,
    input  logic                                  col_valid,
    input  crd_pkg::col_t                         col,
    input  crd_pkg::lane_res_t [OTHER_ROWS-1:0]   lanes,
    output logic                                  col_take,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [crd_pkg::CONTIG_BITS-1:0]       out_contig,
    output logic [crd_pkg::POS_BITS-1:0]          out_start,
    output logic [crd_pkg::POS_BITS:0]            out_end,
    output logic [crd_pkg::DEPTH_BITS-1:0]        out_min_depth
);
    import crd_pkg::*;

    logic [LEN_BITS-1:0]    min_length_reg;
    logic [DEPTH_BITS-1:0]  min_depth_reg;
    logic                   run_open_reg, run_open_next;
    logic [CONTIG_BITS-1:0] run_contig_reg, run_contig_next;
    logic [POS_BITS-1:0]    run_start_reg, run_start_next;
    logic [POS_BITS-1:0]    run_last_reg, run_last_next;
    logic [DEPTH_BITS-1:0]  run_min_reg, run_min_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CONTIG_BITS-1:0] out_contig_reg;
    logic [POS_BITS-1:0]    out_start_reg;
    logic [POS_BITS:0]      out_end_reg;
    logic [DEPTH_BITS-1:0]  out_min_reg;

    logic [SAMPLES-1:0]     seen;
    logic                   any_excl;
    logic [DEPTH_BITS:0]    count;
    logic [DEPTH_BITS-1:0]  depth;
    logic                   deep;
    logic                   adjacent;
    logic                   extend;
    logic                   len_ok;
    logic [POS_BITS:0]      run_len;
    logic                   emit;
    logic                   out_free;

    // Distinct samples among matching rows, not counting the reference sample.
    always_comb
    begin
        seen     = '0;
        any_excl = 1'b0;
        for (int i = 0; i < OTHER_ROWS; i++)
        begin
            seen     = seen | lanes[i].sample_oh;
            any_excl = any_excl | lanes[i].hit_excl;
        end
        seen  = seen & ~col.ref_oh;
        count = '0;
        for (int j = 0; j < SAMPLES; j++)
        begin
            count = count + (DEPTH_BITS+1)'(seen[j]);
        end
        depth = any_excl ? '0 : count[DEPTH_BITS-1:0];
    end

    assign deep     = depth >= min_depth_reg;
    assign adjacent = ({1'b0, col.pos} == ({1'b0, run_last_reg} + 1'b1))
                      && (col.contig == run_contig_reg);
    assign extend   = run_open_reg && deep && adjacent;
    assign run_len  = {1'b0, run_last_reg} - {1'b0, run_start_reg} + 1'b1;
    assign len_ok   = run_len >= (POS_BITS+1)'(min_length_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        emit            = 1'b0;
        run_open_next   = run_open_reg;
        run_contig_next = run_contig_reg;
        run_start_next  = run_start_reg;
        run_last_next   = run_last_reg;
        run_min_next    = run_min_reg;
        if (col.flush)
        begin
            emit          = run_open_reg && len_ok;
            run_open_next = 1'b0;
        end
        else if (!col.gap)
        begin
            if (extend)
            begin
                run_last_next = col.pos;
                if (depth < run_min_reg)
                begin
                    run_min_next = depth;
                end
            end
            else
            begin
                emit          = run_open_reg && len_ok;
                run_open_next = deep;
                if (deep)
                begin
                    run_contig_next = col.contig;
                    run_start_next  = col.pos;
                    run_last_next   = col.pos;
                    run_min_next    = depth;
                end
            end
        end
    end

    assign col_take = col_valid && (!emit || out_free);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (col_take && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= LEN_BITS'(1);
            min_depth_reg  <= DEPTH_BITS'(1);
            run_open_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_LENGTH: min_length_reg <= cfg_data;
                    CFG_MIN_DEPTH:  min_depth_reg  <= cfg_data[DEPTH_BITS-1:0];
                    default:        min_length_reg <= min_length_reg;
                endcase
            end
            if (col_take)
            begin
                run_open_reg <= run_open_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_take)
        begin
            run_contig_reg <= run_contig_next;
            run_start_reg  <= run_start_next;
            run_last_reg   <= run_last_next;
            run_min_reg    <= run_min_next;
            if (emit)
            begin
                out_contig_reg <= run_contig_reg;
                out_start_reg  <= run_start_reg;
                out_end_reg    <= {1'b0, run_last_reg} + 1'b1;
                out_min_reg    <= run_min_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_contig    = out_contig_reg;
    assign out_start     = out_start_reg;
    assign out_end       = out_end_reg;
    assign out_min_depth = out_min_reg;

endmodule

/* rtl/conserved_run_detector.sv */
// Top level of the conserved run detector: stream ports, the row comparison
// lanes, the lane result register and the merge stage. Depends on crd_pkg,
// crd_lane and crd_merge.
//
// Usage. Alignment columns arrive on the s_ stream, one column per
// transaction; s_tuser is the item kind (0 column, 1 end-of-stream flush).
// Each transaction of the m_ stream reports one conserved region. The
// configuration port writes the minimum run length (index 0) and the depth
// threshold (index 1); write it only while no column is in flight.
// A column is compared in its accept cycle and its lane results are
// registered at the accepting edge; the merge stage then updates the run from
// the lane register, and a region that a column closes is loaded into the
// output register, which drives m_tvalid, when the merge stage takes that column.
// Throughput is one column per cycle while the output register can take each region.
// Reset clears the open run, empties both stages and sets both thresholds
// to one. When the receiver stalls, the finished region waits in the output
// register; columns that close no region keep flowing, and the input stalls
// only when a second region would need the occupied output register.
module conserved_run_detector #(
    parameter int OTHER_ROWS = crd_pkg::OTHER_ROWS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [crd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [crd_pkg::LEN_BITS-1:0]           cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // contig_id, ref_position, ref_base, row_bases, row_present, ref_sample,
    // row_samples, row_excluded (lowest bits first), two zero pad bits on top
    input  logic [crd_pkg::IN_DATA_BITS-1:0]       s_tdata,
    // kind
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // region_contig, region_start, region_end, region_min_depth
    // (lowest bits first), four zero pad bits on top
    output logic [crd_pkg::OUT_DATA_BITS-1:0]      m_tdata
);
    import crd_pkg::*;

    // Field offsets within s_tdata.
    localparam int OFF_POS     = CONTIG_BITS;
    localparam int OFF_REF     = OFF_POS + POS_BITS;
    localparam int OFF_BASES   = OFF_REF + 8;
    localparam int OFF_PRESENT = OFF_BASES + 8 * MAX_ROWS;
    localparam int OFF_REFSAMP = OFF_PRESENT + MAX_ROWS;
    localparam int OFF_SAMPLES = OFF_REFSAMP + SAMPLE_BITS;
    localparam int OFF_EXCL    = OFF_SAMPLES + SAMPLE_BITS * MAX_ROWS;
    localparam int OUT_USED    = CONTIG_BITS + 2 * POS_BITS + 1 + DEPTH_BITS;

    logic [7:0]                  ref_base;
    logic [7:0]                  ref_up;
    logic [SAMPLE_BITS-1:0]      ref_sample;
    lane_res_t [OTHER_ROWS-1:0]  lane_res;
    col_t                        col_in;

    logic                        col_valid_reg, col_valid_next;
    col_t                        col_reg;
    lane_res_t [OTHER_ROWS-1:0]  lanes_reg;
    logic                        col_take;
    logic                        s_fire;

    logic [CONTIG_BITS-1:0]      out_contig;
    logic [POS_BITS-1:0]         out_start;
    logic [POS_BITS:0]           out_end;
    logic [DEPTH_BITS-1:0]       out_min_depth;

    assign ref_base   = s_tdata[OFF_REF +: 8];
    assign ref_up     = upcase(ref_base);
    assign ref_sample = s_tdata[OFF_REFSAMP +: SAMPLE_BITS];

    // One comparison lane per other row; rows past OTHER_ROWS are ignored.
    for (genvar g = 0; g < OTHER_ROWS; g++)
    begin : g_lane
        crd_lane u_lane (
            .row_base (s_tdata[OFF_BASES + 8 * g +: 8]),
            .ref_up   (ref_up),
            .present  (s_tdata[OFF_PRESENT + g]),
            .excluded (s_tdata[OFF_EXCL + g]),
            .sample   (s_tdata[OFF_SAMPLES + SAMPLE_BITS * g +: SAMPLE_BITS]),
            .res      (lane_res[g])
        );
    end

    always_comb
    begin
        col_in.flush  = s_tuser;
        col_in.gap    = (ref_base == GAP_CHAR);
        col_in.contig = s_tdata[0 +: CONTIG_BITS];
        col_in.pos    = s_tdata[OFF_POS +: POS_BITS];
        col_in.ref_oh = SAMPLES'(1) << ref_sample;
    end

    // The lane register frees up whenever the merge stage takes its column.
    assign s_tready = !col_valid_reg || col_take;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        col_valid_next = col_valid_reg;
        if (s_fire)
        begin
            col_valid_next = 1'b1;
        end
        else if (col_take)
        begin
            col_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= 1'b0;
        end
        else
        begin
            col_valid_reg <= col_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            col_reg   <= col_in;
            lanes_reg <= lane_res;
        end
    end

    crd_merge #(
        .OTHER_ROWS (OTHER_ROWS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .col_valid     (col_valid_reg),
        .col           (col_reg),
        .lanes         (lanes_reg),
        .col_take      (col_take),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_contig    (out_contig),
        .out_start     (out_start),
        .out_end       (out_end),
        .out_min_depth (out_min_depth)
    );

    assign m_tdata = {(OUT_DATA_BITS - OUT_USED)'(0), out_min_depth, out_end,
                      out_start, out_contig};

endmodule

/* dv/tb_conserved_run_detector.sv */
// Self-checking testbench for conserved_run_detector: directed columns from a table, then
// random column streams under several threshold settings, scored by a local run tracker or by
// expectations typed into the table. Depends on crd_pkg and the conserved_run_detector RTL.
module tb_conserved_run_detector;

    import crd_pkg::*;

    // Column transaction as it travels on s_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [1:0]                    pad;
        logic [MAX_ROWS-1:0]           row_excluded;
        logic [SAMPLE_BITS*MAX_ROWS-1:0] row_samples;
        logic [SAMPLE_BITS-1:0]        ref_sample;
        logic [MAX_ROWS-1:0]           row_present;
        logic [8*MAX_ROWS-1:0]         row_bases;
        logic [7:0]                    ref_base;
        logic [POS_BITS-1:0]           ref_position;
        logic [CONTIG_BITS-1:0]        contig_id;
    } column_t;

    // Region transaction as it travels on m_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [3:0]            pad;
        logic [DEPTH_BITS-1:0] region_min_depth;
        logic [POS_BITS:0]     region_end;
        logic [POS_BITS-1:0]   region_start;
        logic [CONTIG_BITS-1:0] region_contig;
    } region_t;

    // How a directed row gets its expectation: from the run tracker, or typed in.
    typedef enum logic [1:0] {PREDICTED, FIXED_REGION, FIXED_NONE} check_mode_t;

    typedef struct {
        logic        kind;
        column_t     col;
        check_mode_t how;
        region_t     fixed;
    } directed_row_t;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 125;
    // Row r (1..7) carries sample r: every row a different sample, none equal to sample 0.
    localparam logic [SAMPLE_BITS*MAX_ROWS-1:0] DISTINCT = 21'o7654321;

    // Threshold settings walked by the random phases; the last one runs with no idling.
    localparam logic [LEN_BITS-1:0] LEN_STEPS [PHASES] =
        '{32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd5, 32'd1};
    localparam logic [DEPTH_BITS-1:0] DEPTH_STEPS [PHASES] =
        '{3'd1, 3'd2, 3'd0, 3'd7, 3'd7, 3'd4, 3'd3, 3'd1};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_MIN_LENGTH;
    logic [LEN_BITS-1:0]       cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // contig_id, ref_position, ref_base, row_bases, row_present, ref_sample,
    // row_samples, row_excluded (lowest bits first), two zero pad bits on top
    logic [IN_DATA_BITS-1:0]   s_tdata = '0;
    // kind
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // region_contig, region_start, region_end, region_min_depth
    // (lowest bits first), four zero pad bits on top
    logic [OUT_DATA_BITS-1:0]  m_tdata;

    // Local copy of the thresholds, updated whenever the testbench writes a register.
    logic [LEN_BITS-1:0]       len_floor = 32'd1;
    logic [DEPTH_BITS-1:0]     depth_floor = 3'd1;

    // Run tracker state, mirroring the block's open run.
    bit                        run_open = 1'b0;
    logic [CONTIG_BITS-1:0]    run_contig = '0;
    logic [POS_BITS-1:0]       run_start = '0;
    logic [POS_BITS-1:0]       run_last = '0;
    int                        run_low = 0;

    // Regions the tracker has announced and the block has not yet delivered, oldest first.
    region_t                   pending_regions[$];
    directed_row_t             directed_rows[$];

    // Cursor of the random column stream; hot marks a stretch of well-conserved columns.
    logic [CONTIG_BITS-1:0]    cur_contig = '0;
    logic [POS_BITS-1:0]       cur_pos = '0;
    bit                        hot = 1'b1;
    // Set for the final phase: neither side idles any more.
    bit                        calm = 1'b0;

    int                        errors = 0;
    int                        items_sent = 0;
    int                        regions_seen = 0;

    always #10 clk = ~clk;

    conserved_run_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ASCII letters compare without regard to case; every other byte compares as is.
    function automatic logic [7:0] fold_case(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") ? (ch ^ 8'h20) : ch;
    endfunction

    // Number of distinct samples among present rows that match the reference base. The
    // reference sample never counts, and one excluded matching row zeroes the column.
    function automatic int score_column(input column_t c);
        logic [7:0]         want;
        logic [SAMPLES-1:0] seen;
        int                 depth;
        want = fold_case(c.ref_base);
        seen = '0;
        seen[c.ref_sample] = 1'b1;
        depth = 0;
        for (int i = 0; i < OTHER_ROWS_DEF; i++)
        begin
            if (c.row_present[i] && fold_case(c.row_bases[8*i +: 8]) == want)
            begin
                if (c.row_excluded[i])
                begin
                    return 0;
                end
                if (!seen[c.row_samples[SAMPLE_BITS*i +: SAMPLE_BITS]])
                begin
                    seen[c.row_samples[SAMPLE_BITS*i +: SAMPLE_BITS]] = 1'b1;
                    depth++;
                end
            end
        end
        return depth;
    endfunction

    // Ends the open run; a run at least len_floor columns long becomes a region.
    function automatic void close_open_run(output bit found, output region_t r);
        logic [POS_BITS:0] span;
        found = 1'b0;
        r = '0;
        span = {1'b0, run_last} - {1'b0, run_start} + 1'b1;
        if (run_open && span >= {{(POS_BITS+1-LEN_BITS){1'b0}}, len_floor})
        begin
            found = 1'b1;
            r.region_contig = run_contig;
            r.region_start = run_start;
            r.region_end = {1'b0, run_last} + 1'b1;
            r.region_min_depth = run_low[DEPTH_BITS-1:0];
        end
        run_open = 1'b0;
    endfunction

    // Advances the run tracker by one accepted transaction and reports the region it closes.
    function automatic void track_run(input logic kind, input column_t c,
                                      output bit found, output region_t r);
        int depth;
        found = 1'b0;
        r = '0;
        if (kind)
        begin
            close_open_run(found, r);
            return;
        end
        // Gap columns leave the run untouched.
        if (c.ref_base == GAP_CHAR)
        begin
            return;
        end
        depth = score_column(c);
        // The 41-bit compare keeps the top position from ever being followed by zero.
        if (run_open && depth >= depth_floor && c.contig_id == run_contig &&
            {1'b0, c.ref_position} == {1'b0, run_last} + 1'b1)
        begin
            run_last = c.ref_position;
            if (depth < run_low)
            begin
                run_low = depth;
            end
            return;
        end
        close_open_run(found, r);
        if (depth >= depth_floor)
        begin
            run_open = 1'b1;
            run_contig = c.contig_id;
            run_start = c.ref_position;
            run_last = c.ref_position;
            run_low = depth;
        end
    endfunction

    function automatic column_t make_column(
        input logic [CONTIG_BITS-1:0] contig, input logic [POS_BITS-1:0] pos,
        input logic [7:0] ref_base, input logic [8*MAX_ROWS-1:0] bases,
        input logic [MAX_ROWS-1:0] present, input logic [SAMPLE_BITS-1:0] ref_sample,
        input logic [SAMPLE_BITS*MAX_ROWS-1:0] samples, input logic [MAX_ROWS-1:0] excluded);
        column_t c;
        c = '0;
        c.contig_id = contig;
        c.ref_position = pos;
        c.ref_base = ref_base;
        c.row_bases = bases;
        c.row_present = present;
        c.ref_sample = ref_sample;
        c.row_samples = samples;
        c.row_excluded = excluded;
        return c;
    endfunction

    function automatic region_t make_region(
        input logic [CONTIG_BITS-1:0] contig, input logic [POS_BITS-1:0] first,
        input logic [POS_BITS:0] stop, input logic [DEPTH_BITS-1:0] depth);
        region_t r;
        r = '0;
        r.region_contig = contig;
        r.region_start = first;
        r.region_end = stop;
        r.region_min_depth = depth;
        return r;
    endfunction

    task automatic add_row(input logic kind, input column_t c, input check_mode_t how,
                           input region_t fixed);
        directed_row_t row;
        row.kind = kind;
        row.col = c;
        row.how = how;
        row.fixed = fixed;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic [7:0] pick_base();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:       b = "A";
            1:       b = "C";
            2:       b = "G";
            3:       b = "T";
            default: b = "N";
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            b = b | 8'h20;
        end
        return b;
    endfunction

    // One random transaction. Most are columns that walk the cursor forward, so runs grow
    // and close for the usual reasons; the rest are noise with every field random.
    task automatic make_random(output logic kind, output column_t c);
        int         roll;
        bit         distinct;
        bit         alpha;
        logic [7:0] letter;
        logic [7:0] b;
        kind = 1'b0;
        c = '0;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            // Noise; the first few are flushes whose other fields are junk.
            kind = (roll < 3);
            c.contig_id = CONTIG_BITS'($urandom());
            c.ref_position = POS_BITS'({$urandom(), $urandom()});
            c.ref_base = 8'($urandom());
            c.row_bases = (8*MAX_ROWS)'({$urandom(), $urandom()});
            c.row_present = MAX_ROWS'($urandom());
            c.ref_sample = SAMPLE_BITS'($urandom());
            c.row_samples = 21'($urandom());
            c.row_excluded = MAX_ROWS'($urandom());
            return;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            hot = !hot;
        end
        roll = $urandom_range(0, 99);
        if (roll < 82)
        begin
            cur_pos = cur_pos + 1'b1;
        end
        else if (roll < 88)
        begin
            cur_pos = cur_pos + POS_BITS'($urandom_range(2, 5));
        end
        else if (roll < 90)
        begin
            cur_pos = cur_pos - 1'b1;
        end
        else if (roll < 95)
        begin
            cur_contig = CONTIG_BITS'($urandom_range(0, 3));
        end
        else if (roll < 98)
        begin
            // Near the top of the position range, so the position wraps into zero and closes the run.
            cur_pos = '1 - POS_BITS'($urandom_range(0, 3));
        end
        else
        begin
            cur_contig = CONTIG_BITS'($urandom());
            cur_pos = POS_BITS'({$urandom(), $urandom()});
        end
        letter = pick_base();
        if ($urandom_range(0, 49) == 0)
        begin
            letter = 8'($urandom());
        end
        if ($urandom_range(0, 29) == 0)
        begin
            letter = GAP_CHAR;
        end
        alpha = ((letter | 8'h20) >= "a") && ((letter | 8'h20) <= "z");
        distinct = hot && ($urandom_range(0, 9) < 7);
        c.contig_id = cur_contig;
        c.ref_position = cur_pos;
        c.ref_base = letter;
        c.ref_sample = SAMPLE_BITS'($urandom_range(0, SAMPLES - 1));
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            c.row_present[i] = $urandom_range(0, 99) < (hot ? 95 : 60);
            if ($urandom_range(0, 99) < (hot ? 92 : 30))
            begin
                b = letter ^ ((alpha && $urandom_range(0, 1) == 1) ? 8'h20 : 8'h00);
            end
            else
            begin
                b = pick_base();
            end
            c.row_bases[8*i +: 8] = b;
            c.row_samples[SAMPLE_BITS*i +: SAMPLE_BITS] = distinct ?
                SAMPLE_BITS'(c.ref_sample + i + 1) : SAMPLE_BITS'($urandom_range(0, 7));
            c.row_excluded[i] = $urandom_range(0, 99) < 3;
        end
    endtask

    // Presents one transaction on the slave side, optionally after an idle burst, and
    // records its expectation at the edge where it is accepted. Called at a rising edge;
    // returns at the accepting edge with s_tvalid still high.
    task automatic send_item(input logic kind, input column_t c, input check_mode_t how,
                             input region_t fixed);
        bit      found;
        region_t r;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= c;
        do
            @(posedge clk);
        while (!s_tready);
        track_run(kind, c, found, r);
        if (how == FIXED_REGION)
        begin
            found = 1'b1;
            r = fixed;
        end
        else if (how == FIXED_NONE)
        begin
            found = 1'b0;
        end
        if (found)
        begin
            pending_regions.insert(pending_regions.size(), r);
        end
        items_sent++;
    endtask

    // Register write; the extra edge keeps two back-to-back writes from colliding on cfg_we.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [LEN_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_LENGTH)
        begin
            len_floor = value;
        end
        else
        begin
            depth_floor = value[DEPTH_BITS-1:0];
        end
        @(posedge clk);
    endtask

    // Brings the block to rest: no input, every region delivered, and then a wait
    // for a column still in the two-stage pipe that closes nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_regions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Receiver: ready comes in random stretches with idle bursts between them.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Every region transaction is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin : region_check
        region_t got;
        region_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            regions_seen++;
            if (pending_regions.size() == 0)
            begin
                $error("unexpected region: contig %0h start %0h end %0h depth %0d",
                       got.region_contig, got.region_start, got.region_end,
                       got.region_min_depth);
                errors++;
            end
            else
            begin
                want = pending_regions.pop_front();
                if (got.region_contig !== want.region_contig)
                begin
                    $error("region_contig: expected %0h, got %0h",
                           want.region_contig, got.region_contig);
                    errors++;
                end
                if (got.region_start !== want.region_start)
                begin
                    $error("region_start: expected %0h, got %0h",
                           want.region_start, got.region_start);
                    errors++;
                end
                if (got.region_end !== want.region_end)
                begin
                    $error("region_end: expected %0h, got %0h",
                           want.region_end, got.region_end);
                    errors++;
                end
                if (got.region_min_depth !== want.region_min_depth)
                begin
                    $error("region_min_depth: expected %0d, got %0d",
                           want.region_min_depth, got.region_min_depth);
                    errors++;
                end
            end
        end
    end

    // Watchdog, sized well beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $error("watchdog expired with %0d regions outstanding", pending_regions.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic    kind;
        column_t col;
        int      directed_count;

        // Directed part, run with the reset thresholds (length 1, depth 1).
        // A flush with no open run reports nothing.
        add_row(1'b1, '0, FIXED_NONE, '0);
        // Opens a run at contig 0, position 0, depth 1.
        add_row(1'b0, make_column(0, 0, "A", 56'h41, 7'h01, 0, DISTINCT, 0), FIXED_NONE, '0);
        // Lower-case row base still matches.
        add_row(1'b0, make_column(0, 1, "A", 56'h61, 7'h01, 0, DISTINCT, 0), FIXED_NONE, '0);
        // Gap reference column is ignored, even with every row matching it.
        add_row(1'b0, make_column(0, 2, GAP_CHAR, 56'h2D2D2D2D2D2D2D, 7'h7F, 0, DISTINCT, 0),
                FIXED_NONE, '0);
        // Full depth with a lower-case reference.
        add_row(1'b0, make_column(0, 2, "c", 56'h43434343434343, 7'h7F, 0, DISTINCT, 0),
                FIXED_NONE, '0);
        add_row(1'b0, make_column(0, 3, "G", 56'h67676767676767, 7'h7F, 0, DISTINCT, 0),
                PREDICTED, '0);
        // A position jump closes the run 0..3.
        add_row(1'b0, make_column(0, 5, "T", 56'h54, 7'h01, 0, DISTINCT, 0),
                FIXED_REGION, make_region(0, 0, 4, 1));
        // A contig change closes the one-column run at 5.
        add_row(1'b0, make_column(1, 6, "T", 56'h54, 7'h01, 0, DISTINCT, 0),
                FIXED_REGION, make_region(0, 5, 6, 1));
        // A matching excluded row zeroes the depth, closing the run and opening none.
        add_row(1'b0, make_column(1, 7, "T", 56'h5454, 7'h03, 0, DISTINCT, 7'h02),
                FIXED_REGION, make_region(1, 6, 7, 1));
        // A matching row that is absent does not count; nothing open, nothing reported.
        add_row(1'b0, make_column(1, 8, "A", 56'h41, 7'h00, 0, DISTINCT, 0), FIXED_NONE, '0);
        // Two rows of one sample count once.
        add_row(1'b0, make_column(16'hFFFF, 40'hFF_FFFF_FFFE, "A", 56'h4141, 7'h03, 0,
                                  21'o0000033, 0), FIXED_NONE, '0);
        // A row of the reference sample does not count; the other row does.
        add_row(1'b0, make_column(16'hFFFF, 40'hFF_FFFF_FFFF, "A", 56'h4141, 7'h03, 2,
                                  21'o0000052, 0), FIXED_NONE, '0);
        // Nothing follows the top position: position zero closes the run there.
        add_row(1'b0, make_column(16'hFFFF, 0, "A", 56'h41, 7'h01, 0, DISTINCT, 0),
                FIXED_REGION, make_region(16'hFFFF, 40'hFF_FFFF_FFFE, 41'h100_0000_0000, 1));
        // An excluded row that does not match is harmless.
        add_row(1'b0, make_column(16'hFFFF, 1, "A", 56'h41000000000043, 7'h41, 0, DISTINCT,
                                  7'h01), PREDICTED, '0);
        // Every field at its maximum: all rows match but are excluded.
        add_row(1'b0, make_column(16'hFFFF, '1, 8'hFF, '1, '1, '1, '1, '1),
                FIXED_REGION, make_region(16'hFFFF, 0, 2, 1));
        add_row(1'b0, make_column(2, 10, "z", 56'h5A, 7'h01, 0, DISTINCT, 0), FIXED_NONE, '0);
        // Case folding applies to letters only.
        add_row(1'b0, make_column(2, 11, "[", 56'h7B, 7'h01, 0, DISTINCT, 0),
                FIXED_REGION, make_region(2, 10, 11, 1));
        add_row(1'b0, make_column(3, 20, "a", 56'h41, 7'h01, 0, DISTINCT, 0), PREDICTED, '0);
        // Flush reports the open run, and a second flush finds nothing.
        add_row(1'b1, '0, FIXED_REGION, make_region(3, 20, 21, 1));
        add_row(1'b1, '0, FIXED_NONE, '0);
        // Every field zero but row_present: rows match but all carry the reference sample.
        add_row(1'b0, make_column(0, 0, 0, 0, 7'h7F, 0, 0, 0), FIXED_NONE, '0);
        directed_count = directed_rows.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            send_item(directed_rows[k].kind, directed_rows[k].col, directed_rows[k].how,
                      directed_rows[k].fixed);
        end

        // Random phases, one threshold setting each, written while the block is at rest.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == PHASES - 1)
            begin
                calm = 1'b1;
            end
            write_reg(CFG_MIN_LENGTH, LEN_STEPS[p]);
            write_reg(CFG_MIN_DEPTH, LEN_BITS'(DEPTH_STEPS[p]));
            repeat (ITEMS_PER_PHASE)
            begin
                make_random(kind, col);
                send_item(kind, col, PREDICTED, '0);
            end
        end
        // Close whatever run the last phase left open.
        send_item(1'b1, '0, PREDICTED, '0);
        s_tvalid <= 1'b0;

        for (int w = 0; w < 1000 && pending_regions.size() != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (pending_regions.size() != 0)
        begin
            $error("%0d expected regions never arrived", pending_regions.size());
            errors++;
        end

        $display("Sent %0d transactions (%0d directed) across %0d threshold settings.",
                 items_sent, directed_count, PHASES);
        $display("Checked %0d region transactions; %0d mismatches.", regions_seen, errors);
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
